FILE: rtl/core/swhc_pkg.sv
package swhc_pkg;

	localparam int WINDOW = 300;
	localparam int TS_W   = 31;
	localparam int CNT_W  = 32;
	localparam int ADDR_W = $clog2(WINDOW);
	localparam int AGE_W  = TS_W + 1;
	localparam int ENTRY_W = TS_W + CNT_W;

	// timestamp / WINDOW by reciprocal multiply, exact for every TS_W-bit stamp
	localparam int MOD_SH  = TS_W + ADDR_W;
	localparam int RECIP_W = TS_W + 1;
	localparam int QUO_W   = TS_W + RECIP_W - MOD_SH;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << MOD_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic {
		OP_HIT   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_HIT_RD,
		ST_HIT_WR,
		ST_Q_RD,
		ST_Q_ACC,
		ST_Q_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic ld_item;
		logic mod_step;
		logic hit_rd;
		logic hit_wr;
		logic q_rd;
		logic clr_wr;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic mod_last;
		logic sweep_last;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/core/sliding_window_hit_counter_top.sv
// sliding window hit counter: counts hit requests over the last 300 seconds
// with one bucket per second (bucket = timestamp mod 300), each bucket holding
// its second and a saturating 32-bit count in a single-port-style block ram.
// a hit request (tuser 0) goes through the reciprocal-multiply modulo that
// picks the bucket (quotient, then multiply back and subtract), one ram read,
// one ram write and a return to idle before the next accept; it gives no
// result. a query request (tuser 1) sweeps all 300 buckets through the ram
// read port, one per cycle, and returns the saturated sum of buckets whose
// stamp is nonzero and less than 300 seconds old (newer stamps count too);
// the result is loaded into the output register, and the next request can be
// taken while it waits there. a second query holds in its last cycle until
// that register frees up. one request is worked at a time. after reset a
// clearing pass writes zero to all 300 buckets, during which s_tready stays
// low. timestamps should be nondecreasing; a hit at second 0 is never counted.
module sliding_window_hit_counter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] timestamp, [31] zero
	input  logic        s_tuser,   // [0] operation: 0 hit, 1 query
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] hit_total
);

	swhc_pkg::cmd_t  cmd;
	swhc_pkg::stat_t stat;

	// sequencing of clearing pass, bucket update and window sweep
	swhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// bucket ram, modulo unit, accumulator and output register
	swhc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_ts     (s_tdata[swhc_pkg::TS_W-1:0]),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTHESIS
	// a hit request never produces a result
	a_hit_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == swhc_pkg::OP_HIT) |=> !$rose(m_tvalid))
		else $error("result raised after a hit request");

	// one request at a time: no back-to-back accepts
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in progress");

	// a result only appears after the controller loads it
	a_result_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result valid without a load");
`endif

endmodule

FILE: rtl/core/swhc_ram.sv
module swhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/swhc_ctrl.sv
module swhc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           s_op,
	output logic           s_tready,
	input  swhc_pkg::stat_t stat,
	output swhc_pkg::cmd_t  cmd
);

	swhc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swhc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			swhc_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.sweep_last) begin
					state_d = swhc_pkg::ST_IDLE;
				end
			end
			swhc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.ld_item = 1'b1;
					if (s_op == swhc_pkg::OP_QUERY) begin
						state_d = swhc_pkg::ST_Q_RD;
					end else begin
						state_d = swhc_pkg::ST_MOD;
					end
				end
			end
			swhc_pkg::ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = swhc_pkg::ST_HIT_RD;
				end
			end
			swhc_pkg::ST_HIT_RD: begin
				cmd.hit_rd = 1'b1;
				state_d    = swhc_pkg::ST_HIT_WR;
			end
			swhc_pkg::ST_HIT_WR: begin
				cmd.hit_wr = 1'b1;
				state_d    = swhc_pkg::ST_IDLE;
			end
			swhc_pkg::ST_Q_RD: begin
				cmd.q_rd = 1'b1;
				if (stat.sweep_last) begin
					state_d = swhc_pkg::ST_Q_ACC;
				end
			end
			swhc_pkg::ST_Q_ACC: begin
				state_d = swhc_pkg::ST_Q_OUT;
			end
			swhc_pkg::ST_Q_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = swhc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swhc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/swhc_dp.sv
module swhc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [swhc_pkg::TS_W-1:0]     s_ts,
	input  swhc_pkg::cmd_t                cmd,
	output swhc_pkg::stat_t               stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [swhc_pkg::CNT_W-1:0]    m_tdata
);

	logic [swhc_pkg::TS_W-1:0]    ts_q;
	logic [swhc_pkg::ADDR_W-1:0]  slot_q;
	logic                         mod_ph_q;
	logic [swhc_pkg::QUO_W-1:0]   quo_q;
	logic [swhc_pkg::ADDR_W-1:0]  sweep_q;
	logic                         rd_vld_s1;
	logic [swhc_pkg::CNT_W-1:0]   acc_q;
	logic                         out_vld_q;
	logic [swhc_pkg::CNT_W-1:0]   out_q;

	logic [swhc_pkg::TS_W+swhc_pkg::RECIP_W-1:0] mod_prod;
	logic [swhc_pkg::TS_W-1:0]    quo_back;
	logic [swhc_pkg::TS_W-1:0]    mod_rem;
	logic                         sweep_last;

	logic                         ram_we;
	logic                         ram_re;
	logic [swhc_pkg::ADDR_W-1:0]  ram_addr;
	logic [swhc_pkg::ENTRY_W-1:0] ram_wdata;
	logic [swhc_pkg::ENTRY_W-1:0] ram_rdata;

	logic [swhc_pkg::TS_W-1:0]    rd_sec;
	logic [swhc_pkg::CNT_W-1:0]   rd_cnt;
	logic [swhc_pkg::CNT_W-1:0]   hit_cnt;
	logic [swhc_pkg::AGE_W-1:0]   age;
	logic                         in_window;
	logic [swhc_pkg::CNT_W:0]     acc_sum;

	// bucket = ts mod window: the quotient by reciprocal multiply is registered
	// first, then multiply back and subtract give the remainder
	assign mod_prod = {{swhc_pkg::RECIP_W{1'b0}}, ts_q} *
		{{swhc_pkg::TS_W{1'b0}}, swhc_pkg::RECIP};
	assign quo_back = swhc_pkg::TS_W'(quo_q) * swhc_pkg::TS_W'(swhc_pkg::WINDOW);
	assign mod_rem  = ts_q - quo_back;

	assign sweep_last = (sweep_q == swhc_pkg::ADDR_W'(swhc_pkg::WINDOW - 1));

	assign rd_sec = ram_rdata[swhc_pkg::TS_W-1:0];
	assign rd_cnt = ram_rdata[swhc_pkg::ENTRY_W-1:swhc_pkg::TS_W];

	always_comb begin
		if (rd_sec == ts_q) begin
			hit_cnt = (rd_cnt == swhc_pkg::CNT_MAX) ? rd_cnt
				: rd_cnt + swhc_pkg::CNT_W'(1);
		end else begin
			hit_cnt = swhc_pkg::CNT_W'(1);
		end
	end

	assign ram_we    = cmd.hit_wr | cmd.clr_wr;
	assign ram_re    = cmd.hit_rd | cmd.q_rd;
	assign ram_addr  = (cmd.hit_rd | cmd.hit_wr) ? slot_q : sweep_q;
	assign ram_wdata = cmd.clr_wr ? '0 : {hit_cnt, ts_q};

	swhc_ram #(
		.WIDTH (swhc_pkg::ENTRY_W),
		.DEPTH (swhc_pkg::WINDOW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// stamps newer than the query give a negative age and still count
	assign age       = {1'b0, ts_q} - {1'b0, rd_sec};
	assign in_window = (rd_sec != '0) &&
		($signed(age) < $signed(swhc_pkg::AGE_W'(swhc_pkg::WINDOW)));
	assign acc_sum   = {1'b0, acc_q} + {1'b0, rd_cnt};

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			ts_q     <= s_ts;
			mod_ph_q <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (cmd.mod_step) begin
				quo_q    <= mod_prod[swhc_pkg::TS_W+swhc_pkg::RECIP_W-1:swhc_pkg::MOD_SH];
				slot_q   <= mod_rem[swhc_pkg::ADDR_W-1:0];
				mod_ph_q <= 1'b1;
			end
			if (rd_vld_s1 && in_window) begin
				acc_q <= acc_sum[swhc_pkg::CNT_W] ? swhc_pkg::CNT_MAX
					: acc_sum[swhc_pkg::CNT_W-1:0];
			end
		end
		if (cmd.out_load) begin
			out_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.q_rd;
			if (cmd.q_rd || cmd.clr_wr) begin
				sweep_q <= sweep_last ? '0 : sweep_q + swhc_pkg::ADDR_W'(1);
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign stat.mod_last   = mod_ph_q;
	assign stat.sweep_last = sweep_last;
	assign stat.out_free   = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the bucket stores plus the queue of totals still owed
	class hit_window_board;
		logic [swhc_pkg::TS_W-1:0]  stamp [swhc_pkg::WINDOW];
		logic [swhc_pkg::CNT_W-1:0] hits  [swhc_pkg::WINDOW];
		logic [swhc_pkg::CNT_W-1:0] pending_totals [$];
		int                         errors;

		function new();
			for (int k = 0; k < swhc_pkg::WINDOW; k++) begin
				stamp[k] = '0;
				hits[k]  = '0;
			end
			errors = 0;
		endfunction

		// bump or restamp the bucket picked by the second
		function void record_hit(logic [swhc_pkg::TS_W-1:0] ts);
			int unsigned slot;
			slot = {1'b0, ts} % swhc_pkg::WINDOW;
			if (stamp[slot] == ts) begin
				if (hits[slot] != swhc_pkg::CNT_MAX)
					hits[slot]++;
			end else begin
				stamp[slot] = ts;
				hits[slot]  = swhc_pkg::CNT_W'(1);
			end
		endfunction

		// saturating sum over nonempty buckets younger than the window;
		// stamps newer than the query give a negative age and count too
		function logic [swhc_pkg::CNT_W-1:0] window_total(logic [swhc_pkg::TS_W-1:0] ts);
			longint unsigned sum;
			longint          age;
			sum = 0;
			for (int k = 0; k < swhc_pkg::WINDOW; k++) begin
				age = longint'({1'b0, ts}) - longint'({1'b0, stamp[k]});
				if (stamp[k] != '0 && age < swhc_pkg::WINDOW) begin
					sum += hits[k];
					if (sum > swhc_pkg::CNT_MAX)
						sum = swhc_pkg::CNT_MAX;
				end
			end
			return sum[swhc_pkg::CNT_W-1:0];
		endfunction

		function void note_request(swhc_pkg::op_t op, logic [swhc_pkg::TS_W-1:0] ts);
			if (op == swhc_pkg::OP_HIT)
				record_hit(ts);
			else
				pending_totals.push_back(window_total(ts));
		endfunction

		function void flag(string what, logic [swhc_pkg::CNT_W-1:0] want,
			logic [swhc_pkg::CNT_W-1:0] got);
			errors++;
			if (errors <= 10)
				$display("mismatch at %0t: %s, expected %0d got %0d", $time, what, want, got);
		endfunction

		function void check_total(logic [swhc_pkg::CNT_W-1:0] got);
			logic [swhc_pkg::CNT_W-1:0] want;
			if (pending_totals.size() == 0) begin
				flag("total with no query outstanding", 'x, got);
				return;
			end
			want = pending_totals.pop_front();
			if (got !== want)
				flag("hit_total", want, got);
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [30:0] timestamp, [31] zero
	logic        s_tuser  = 1'b0; // [0] operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [31:0] hit_total

	hit_window_board board = new();
	int unsigned     requests_sent = 0;
	bit              steady = 1'b0;   // when set neither side idles
	int unsigned     stall_left = 0;

	sliding_window_hit_counter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run (clearing pass, every
	// query waiting out the longest stall, every request after its longest gap)
	initial begin
		#48_000_000;
		$display("testbench: errors");
		$finish;
	end

	// result side: check every accepted total, stall in long random bursts
	// so the output register fills and backs up the request side
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_total(m_tdata);
			if (stall_left > 0)
				stall_left--;
			else if (!steady && $urandom_range(0, 499) == 0)
				stall_left = $urandom_range(1, 400);
			m_tready <= (stall_left == 0);
		end
	end

	// one request; an optional idle gap first, then hold tvalid until taken
	task automatic send_request(swhc_pkg::op_t op, logic [swhc_pkg::TS_W-1:0] ts);
		int unsigned gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 29)
			gap = $urandom_range(1, 80);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, ts};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_request(op, ts);
		requests_sent++;
	endtask

	// edge cases: second zero, bucket reuse one window later, restamp by an
	// older second, stamps newer than the query, window edge, extreme seconds
	task automatic run_directed();
		send_request(swhc_pkg::OP_HIT,   31'd0);
		send_request(swhc_pkg::OP_QUERY, 31'd0);
		send_request(swhc_pkg::OP_HIT,   31'd1);
		send_request(swhc_pkg::OP_HIT,   31'd1);
		send_request(swhc_pkg::OP_HIT,   31'd2);
		send_request(swhc_pkg::OP_QUERY, 31'd2);
		send_request(swhc_pkg::OP_HIT,   31'd301);
		send_request(swhc_pkg::OP_QUERY, 31'd301);
		send_request(swhc_pkg::OP_QUERY, 31'd302);
		send_request(swhc_pkg::OP_HIT,   31'd600);
		send_request(swhc_pkg::OP_HIT,   31'd300);
		send_request(swhc_pkg::OP_QUERY, 31'd299);
		send_request(swhc_pkg::OP_QUERY, 31'd0);
		send_request(swhc_pkg::OP_HIT,   31'h7fff_ffff);
		send_request(swhc_pkg::OP_HIT,   31'h7fff_ffff);
		send_request(swhc_pkg::OP_HIT,   31'h7fff_fffe);
		send_request(swhc_pkg::OP_QUERY, 31'h7fff_ffff);
		send_request(swhc_pkg::OP_QUERY, 31'd1);
		send_request(swhc_pkg::OP_HIT,   31'h2aaa_aaaa);
		send_request(swhc_pkg::OP_HIT,   31'h5555_5555);
		send_request(swhc_pkg::OP_QUERY, 31'h5555_5555);
		send_request(swhc_pkg::OP_QUERY, 31'h2aaa_aaaa);
	endtask

	// runs of nondecreasing time from a random base: mostly repeats and small
	// steps so buckets pile up, some jumps across the window, a few steps
	// back in time and some requests at a random second as noise
	task automatic run_random(int unsigned target);
		logic [swhc_pkg::TS_W-1:0] now;
		longint                    next;
		int unsigned               pick;
		int unsigned               left;
		swhc_pkg::op_t             op;
		while (requests_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				now = swhc_pkg::TS_W'($urandom_range(1, 4000));
			else if (pick < 8)
				now = swhc_pkg::TS_W'($urandom);
			else
				now = swhc_pkg::TS_W'(32'h7fff_ffff - $urandom_range(0, 3000));
			if (now == '0)
				now = swhc_pkg::TS_W'(1);
			left = $urandom_range(20, 120);
			while (left > 0 && requests_sent < target) begin
				steady = (requests_sent >= 600 && requests_sent < 800);
				next = longint'({1'b0, now});
				pick = $urandom_range(0, 99);
				if (pick < 55)
					next = next;
				else if (pick < 80)
					next += $urandom_range(1, 3);
				else if (pick < 92)
					next += $urandom_range(4, 60);
				else if (pick < 97)
					next += $urandom_range(250, 350);
				else
					next -= $urandom_range(1, 400);
				if (next < 1)
					next = 1;
				if (next > 64'h7fff_ffff)
					next = 64'h7fff_ffff;
				now = next[swhc_pkg::TS_W-1:0];
				if ($urandom_range(0, 99) < 4) begin
					op = swhc_pkg::op_t'($urandom_range(0, 1));
					send_request(op, swhc_pkg::TS_W'($urandom));
				end else begin
					op = ($urandom_range(0, 99) < 25) ? swhc_pkg::OP_QUERY : swhc_pkg::OP_HIT;
					send_request(op, now);
				end
				left--;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// the clearing pass after reset holds s_tready low; the first
		// request simply waits for it
		run_directed();
		run_random(1550);
		steady = 1'b0;
		s_tvalid <= 1'b0;
		while (board.pending_totals.size() != 0)
			@(posedge clk);
		// one full sweep of slack for anything still in flight
		repeat (350) @(posedge clk);
		if (board.pending_totals.size() != 0)
			$display("%0d totals never arrived", board.pending_totals.size());
		if (board.errors == 0 && board.pending_totals.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/swhc_pkg.sv
rtl/core/swhc_ram.sv
rtl/core/swhc_ctrl.sv
rtl/core/swhc_dp.sv
rtl/core/sliding_window_hit_counter_top.sv
tb/testbench.sv
